/* hw/rtl/htrpid_pkg.sv */
// Shared constants and types for the heater PID controller with resistive sensing.
// Used by heater_pid_with_resistive_sensing; depends on nothing else.

package htrpid_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed field widths
  localparam int DRIVE_W    = 8;
  localparam int TEMP_W     = 26;
  localparam int SETPOINT_W = 19;
  localparam int GAIN_W     = 16;
  localparam int CFG_DATA_W = 19;
  localparam int REG_IDX_W  = 3;

  // Conversion constants: T = (raw - 10*drive) * 12500 / (431 * drive) + 25
  localparam int CONV_NUM_K    = 12500;
  localparam int CONV_DEN_K    = 431;
  localparam int TEMP_OFFSET_C = 25;
  localparam int TEMP_MAX_C    = 120000;
  localparam int TEMP_MIN_C    = 300;   // magnitude of the lower limit

  // Register reset values
  localparam logic [DRIVE_W-1:0]           DRIVE_RESET    = 8'd232;
  localparam logic signed [SETPOINT_W-1:0] SETPOINT_RESET = 19'sd25600;
  localparam logic [GAIN_W-1:0]            PROP_RESET     = 16'd3840;
  localparam logic [GAIN_W-1:0]            INTEG_RESET    = 16'd768;
  localparam logic [GAIN_W-1:0]            DERIV_RESET    = 16'd0;
  localparam logic [DRIVE_W-1:0]           FLOOR_RESET    = 8'd0;
  localparam logic [DRIVE_W-1:0]           CEILING_RESET  = 8'd255;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SETPOINT = 3'd0,
    REG_PROP     = 3'd1,
    REG_INTEG    = 3'd2,
    REG_DERIV    = 3'd3,
    REG_FLOOR    = 3'd4,
    REG_CEILING  = 3'd5
  } reg_index_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_NUM  = 11'b000_0000_0010,
    S_DEN  = 11'b000_0000_0100,
    S_DIVI = 11'b000_0000_1000,
    S_DIV  = 11'b000_0001_0000,
    S_TEMP = 11'b000_0010_0000,
    S_KI   = 11'b000_0100_0000,
    S_KP   = 11'b000_1000_0000,
    S_KD   = 11'b001_0000_0000,
    S_ACC  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

endpackage

/* hw/rtl/heater_pid_with_resistive_sensing.sv */
// Heater PID controller: converts a heater sense sample to temperature and runs one PID step.
// Uses htrpid_pkg for widths, constants, register indexes and the sequencer states.
//
//  channel   direction  fields (lowest bit up)                          beat when
//  s_axis    in         tdata: raw_sample                               tvalid & tready
//  m_axis    out        tdata: drive_code, temperature_q8; tuser: fault tvalid & tready
//  cfg       in         cfg_index, cfg_data                             cfg_write
//
//  An item runs from its beat through conversion, division and the PID steps to a result;
//  the restoring divider, one quotient bit a cycle, is the longest step, and a saturated
//  quotient skips the loop. A sample taken at zero drive goes straight to the done step.
//  One shared 17 x (FRACTION_BITS+19) multiplier serves every product. s_axis_tready
//  is high only while no item is at work; a result waiting on m_axis does not block it.
//  Reset is synchronous; it restores the registers and the controller state.

module heater_pid_with_resistive_sensing #(
  parameter int SAMPLE_BITS   = htrpid_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = htrpid_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,   // raw_sample
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [39:0]                            m_axis_tdata,   // drive_code, temperature_q8
  output logic                                   m_axis_tuser,   // sensor_fault
  input  logic                                   cfg_write,
  input  logic [htrpid_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [htrpid_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import htrpid_pkg::*;

  localparam int MAGW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam int DFW  = MAGW + 2;
  localparam int MA   = 17;
  localparam int MB   = FRACTION_BITS + 19;
  localparam int PW   = MA + MB;
  localparam int NUMW = MAGW + 14 + FRACTION_BITS;
  localparam int DIVW = 17;
  localparam int QW   = FRACTION_BITS + 17;
  localparam int CW   = DIVW + QW;
  localparam int CNTW = $clog2(QW);
  localparam int TSW  = QW + 2;
  localparam int TW   = QW + 1;
  localparam int IW   = FRACTION_BITS + 9;
  localparam int ISW  = PW + 1;
  localparam int AW   = PW + 2;

  localparam logic signed [TSW-1:0] TOFF =
    TSW'(longint'(TEMP_OFFSET_C) << FRACTION_BITS);
  localparam logic signed [TSW-1:0] TMAX =
    TSW'(longint'(TEMP_MAX_C) << FRACTION_BITS);
  localparam logic signed [TSW-1:0] TMIN =
    TSW'(-(longint'(TEMP_MIN_C) << FRACTION_BITS));

  // Configuration registers
  logic signed [SETPOINT_W-1:0] setpoint;
  logic [GAIN_W-1:0]            prop_gain;
  logic [GAIN_W-1:0]            integ_gain;
  logic [GAIN_W-1:0]            deriv_gain;
  logic [DRIVE_W-1:0]           drive_floor;
  logic [DRIVE_W-1:0]           drive_ceiling;

  // Controller state
  logic signed [IW-1:0]         integrator;
  logic signed [TW-1:0]         prev_temp;
  logic [DRIVE_W-1:0]           drive_level;

  // Sequencer and datapath
  state_t                       st;
  logic [MAGW-1:0]              mag;
  logic                         neg;
  logic signed [PW-1:0]         prod;
  logic [NUMW-1:0]              num;
  logic [NUMW-1:0]              rem;
  logic [CW-2:0]                dreg;
  logic [QW-1:0]                quo;
  logic [CNTW-1:0]              div_cnt;
  logic signed [TW-1:0]         temp;
  logic signed [AW-1:0]         acc;
  logic                         res_fault;

  // Output register
  logic                         out_valid;
  logic [DRIVE_W-1:0]           out_drive;
  logic [TEMP_W-1:0]            out_temp;
  logic                         out_fault;

  logic                         s_fire;
  logic                         out_free;
  logic [SAMPLE_BITS-1:0]       raw;
  logic [11:0]                  times10;
  logic signed [DFW-1:0]        diff;
  logic signed [MA-1:0]         mul_a;
  logic signed [MB-1:0]         mul_b;
  logic signed [MB-1:0]         err;
  logic signed [MB-1:0]         delta;
  logic signed [PW-1:0]         pterm;
  logic [DIVW-1:0]              den;
  logic                         sat_hit;
  logic [CW-2:0]                rem_ext;
  logic                         rem_ge;
  logic signed [TSW-1:0]        sq;
  logic signed [TSW-1:0]        tsum;
  logic signed [TSW-1:0]        tsat;
  logic signed [IW-1:0]         lim_lo;
  logic signed [IW-1:0]         lim_hi;
  logic signed [ISW-1:0]        isum;
  logic signed [IW-1:0]         iclamp;
  logic signed [AW-1:0]         usum;
  logic signed [IW-1:0]         uclamp;

  assign s_axis_tready = (st == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_temp, out_drive};
  assign m_axis_tuser  = out_fault;

  // Sample minus the heater offset, split into sign and magnitude
  assign raw     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign times10 = 12'({drive_level, 3'b000}) + 12'({drive_level, 1'b0});
  assign diff    = DFW'($signed({1'b0, raw})) - DFW'($signed({1'b0, times10}));

  assign err   = MB'(setpoint) - MB'(temp);
  assign delta = MB'(temp) - MB'(prev_temp);
  assign pterm = prod >>> FRACTION_BITS;

  // Shared multiplier operand select
  always_comb begin
    case (st)
      S_NUM: begin
        mul_a = MA'($signed({1'b0, mag}));
        mul_b = MB'(CONV_NUM_K);
      end
      S_DEN: begin
        mul_a = MA'($signed({1'b0, drive_level}));
        mul_b = MB'(CONV_DEN_K);
      end
      S_KI: begin
        mul_a = $signed({1'b0, integ_gain});
        mul_b = err;
      end
      S_KP: begin
        mul_a = $signed({1'b0, prop_gain});
        mul_b = err;
      end
      S_KD: begin
        mul_a = $signed({1'b0, deriv_gain});
        mul_b = delta;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider: a quotient of 2^QW or more saturates the temperature either way
  assign den     = prod[DIVW-1:0];
  assign sat_hit = CW'(num) >= {den, {QW{1'b0}}};
  assign rem_ext = (CW-1)'(rem);
  assign rem_ge  = rem_ext >= dreg;

  assign sq   = TSW'(quo);
  assign tsum = (neg ? -sq : sq) + TOFF;
  assign tsat = (tsum > TMAX) ? TMAX : ((tsum < TMIN) ? TMIN : tsum);

  // Drive limits in fixed point; the ceiling is tested first
  assign lim_lo = $signed({1'b0, drive_floor, {FRACTION_BITS{1'b0}}});
  assign lim_hi = $signed({1'b0, drive_ceiling, {FRACTION_BITS{1'b0}}});
  assign isum   = ISW'(integrator) + ISW'(pterm);
  assign iclamp = (isum > ISW'(lim_hi)) ? lim_hi :
                  ((isum < ISW'(lim_lo)) ? lim_lo : IW'(isum));
  assign usum   = acc - AW'(pterm);
  assign uclamp = (usum > AW'(lim_hi)) ? lim_hi :
                  ((usum < AW'(lim_lo)) ? lim_lo : IW'(usum));

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= SETPOINT_RESET;
      prop_gain     <= PROP_RESET;
      integ_gain    <= INTEG_RESET;
      deriv_gain    <= DERIV_RESET;
      drive_floor   <= FLOOR_RESET;
      drive_ceiling <= CEILING_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETPOINT: setpoint      <= $signed(cfg_data[SETPOINT_W-1:0]);
        REG_PROP:     prop_gain     <= cfg_data[GAIN_W-1:0];
        REG_INTEG:    integ_gain    <= cfg_data[GAIN_W-1:0];
        REG_DERIV:    deriv_gain    <= cfg_data[GAIN_W-1:0];
        REG_FLOOR:    drive_floor   <= cfg_data[DRIVE_W-1:0];
        REG_CEILING:  drive_ceiling <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      out_valid   <= 1'b0;
      integrator  <= '0;
      prev_temp   <= '0;
      drive_level <= DRIVE_RESET;
    end else begin
      // load a finished result, else drop the beat just taken
      if ((st == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (s_fire) begin
            neg       <= diff[DFW-1];
            mag       <= diff[DFW-1] ? MAGW'(-diff) : MAGW'(diff);
            res_fault <= (drive_level == '0);
            st        <= (drive_level == '0) ? S_DONE : S_NUM;
          end
        end
        S_NUM: begin
          st <= S_DEN;
        end
        S_DEN: begin
          num <= {prod[MAGW+13:0], {FRACTION_BITS{1'b0}}};
          st  <= S_DIVI;
        end
        S_DIVI: begin
          rem     <= num;
          dreg    <= {den, {(QW-1){1'b0}}};
          div_cnt <= CNTW'(QW - 1);
          if (sat_hit) begin
            quo <= '1;
            st  <= S_TEMP;
          end else begin
            quo <= '0;
            st  <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_ge) begin
            rem <= NUMW'(rem_ext - dreg);
          end
          quo     <= {quo[QW-2:0], rem_ge};
          dreg    <= dreg >> 1;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            st <= S_TEMP;
          end
        end
        S_TEMP: begin
          temp <= TW'(tsat);
          st   <= S_KI;
        end
        S_KI: begin
          st <= S_KP;
        end
        S_KP: begin
          integrator <= iclamp;
          st         <= S_KD;
        end
        S_KD: begin
          acc <= AW'(pterm) + AW'(integrator);
          st  <= S_ACC;
        end
        S_ACC: begin
          drive_level <= uclamp[FRACTION_BITS+7:FRACTION_BITS];
          prev_temp   <= temp;
          st          <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_drive <= drive_level;
            out_temp  <= res_fault ? '0 : TEMP_W'(temp);
            out_fault <= res_fault;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fault_path: assert property (@(posedge clk) disable iff (rst)
    s_fire && (drive_level == '0) |=> (st == S_DONE) && res_fault)
    else $error("zero-drive sample did not take the fault path");

  a_integ_nonneg: assert property (@(posedge clk) disable iff (rst)
    integrator >= 0)
    else $error("integrator left the drive range");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == S_DONE))
    else $error("result raised outside the done step");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV) |-> ({1'b0, rem_ext} < {dreg, 1'b0}))
    else $error("divider remainder out of bound");
`endif

endmodule
